### sv/lsw_pkg.sv
package lsw_pkg;

    localparam int TIME_W      = 48;
    localparam int LIMIT_W     = 5;
    localparam int AGE_W       = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT     = 1'd1;

    localparam logic [LIMIT_W-1:0] REQUEST_LIMIT_RESET = 5'd10;
    localparam logic [AGE_W-1:0]   AGE_LIMIT_RESET     = 32'd2000000;

    typedef logic [TIME_W-1:0] stamp_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

### sv/lsw_if.sv
interface lsw_req_if;
    logic                 valid;
    logic                 ready;
    lsw_pkg::stamp_t      request_time;

    modport source (output valid, output request_time, input ready);
    modport sink   (input valid, input request_time, output ready);
endinterface

interface lsw_res_if;
    logic                              valid;
    logic                              ready;
    logic                              allowed;
    logic [lsw_pkg::COUNT_OUT_W-1:0]   live_count;

    modport source (output valid, output allowed, output live_count, input ready);
    modport sink   (input valid, input allowed, input live_count, output ready);
endinterface

### sv/sliding_window_log_rate_limiter.sv
// Sliding-window-log rate limiter. Each request beat carries a 48-bit
// time stamp and yields one result beat: allowed, and the number of entries
// left in the log. Admitted times sit in a row of LOG_DEPTH cells, oldest at
// the head cell; an entry is live while (request_time - entry) mod 2^48 is
// below age_limit_ticks. One request is handled at a time: it is taken in
// ST_IDLE and judged in ST_DECIDE; when the log is at the limit and the head
// entry has expired, ST_POP first drops the expired entries. The pop pass is
// paced by the cell row, which shifts one entry toward the head per cycle, and
// by the single age compare on the head cell. A full output register stalls
// the verdict; a finished one waits there while the next request is taken.
// Registers: index 0 request_limit (0 acts as 1, values above LOG_DEPTH act
// as LOG_DEPTH), index 1 age_limit_ticks.
module sliding_window_log_rate_limiter #(
    parameter int LOG_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    lsw_req_if.sink                             req,
    lsw_res_if.source                           res,
    input  logic                                cfg_we,
    input  logic [lsw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lsw_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW   = $clog2(LOG_DEPTH + 1);
    localparam int CMPW = (CW > lsw_pkg::LIMIT_W) ? CW : lsw_pkg::LIMIT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_POP
    } state_t;

    state_t                               state_reg, state_next;
    logic [CW-1:0]                        count_reg, count_next;
    lsw_pkg::stamp_t                      now_reg, now_next;
    logic                                 out_valid_reg, out_valid_next;
    logic                                 allowed_reg, allowed_next;
    logic [lsw_pkg::COUNT_OUT_W-1:0]      live_count_reg, live_count_next;
    logic [lsw_pkg::LIMIT_W-1:0]          request_limit_reg, request_limit_next;
    logic [lsw_pkg::AGE_W-1:0]            age_limit_reg, age_limit_next;

    lsw_pkg::stamp_t                      stamps [LOG_DEPTH];
    lsw_pkg::cell_ctrl_t                  ctrls  [LOG_DEPTH];
    logic                                 push;
    logic                                 shift;

    lsw_pkg::stamp_t                      head_age;
    logic                                 head_live;
    logic [CMPW-1:0]                      limit_eff;
    logic                                 below_limit;
    logic                                 out_free;

    genvar gi;
    generate
        for (gi = 0; gi < LOG_DEPTH; gi++)
        begin : g_cell
            lsw_pkg::stamp_t neighbor;
            if (gi == LOG_DEPTH - 1)
            begin : g_tail
                assign neighbor = stamps[gi];
            end
            else
            begin : g_mid
                assign neighbor = stamps[gi + 1];
            end

            assign ctrls[gi].shift = shift;
            assign ctrls[gi].load  = push && (count_reg == CW'(gi));

            lsw_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrls[gi]),
                .now      (now_reg),
                .neighbor (neighbor),
                .stamp    (stamps[gi])
            );
        end
    endgenerate

    assign head_age  = now_reg - stamps[0];
    assign head_live = head_age < {{(lsw_pkg::TIME_W - lsw_pkg::AGE_W){1'b0}}, age_limit_reg};

    always_comb
    begin
        limit_eff = CMPW'(request_limit_reg);
        if (request_limit_reg == '0)
        begin
            limit_eff = CMPW'(1);
        end
        else if (CMPW'(request_limit_reg) > CMPW'(LOG_DEPTH))
        begin
            limit_eff = CMPW'(LOG_DEPTH);
        end
    end

    assign below_limit = CMPW'(count_reg) < limit_eff;
    assign out_free    = !out_valid_reg || res.ready;

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        now_next           = now_reg;
        out_valid_next     = out_valid_reg && !res.ready;
        allowed_next       = allowed_reg;
        live_count_next    = live_count_reg;
        request_limit_next = request_limit_reg;
        age_limit_next     = age_limit_reg;
        push               = 1'b0;
        shift              = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                lsw_pkg::CFG_REQUEST_LIMIT: request_limit_next = cfg_data[lsw_pkg::LIMIT_W-1:0];
                lsw_pkg::CFG_AGE_LIMIT:     age_limit_next     = cfg_data[lsw_pkg::AGE_W-1:0];
                default:                    ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    now_next   = req.request_time;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (below_limit)
                begin
                    if (out_free)
                    begin
                        push            = 1'b1;
                        count_next      = count_reg + CW'(1);
                        out_valid_next  = 1'b1;
                        allowed_next    = 1'b1;
                        live_count_next = lsw_pkg::COUNT_OUT_W'(count_reg + CW'(1));
                        state_next      = ST_IDLE;
                    end
                end
                else if (head_live)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        allowed_next    = 1'b0;
                        live_count_next = lsw_pkg::COUNT_OUT_W'(count_reg);
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (count_reg != '0 && !head_live)
                begin
                    shift      = 1'b1;
                    count_next = count_reg - CW'(1);
                end
                else if (out_free)
                begin
                    if (count_reg != CW'(LOG_DEPTH))
                    begin
                        push            = 1'b1;
                        count_next      = count_reg + CW'(1);
                        live_count_next = lsw_pkg::COUNT_OUT_W'(count_reg + CW'(1));
                    end
                    else
                    begin
                        live_count_next = lsw_pkg::COUNT_OUT_W'(count_reg);
                    end
                    out_valid_next = 1'b1;
                    allowed_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            count_reg         <= '0;
            now_reg           <= '0;
            out_valid_reg     <= 1'b0;
            allowed_reg       <= 1'b0;
            live_count_reg    <= '0;
            request_limit_reg <= lsw_pkg::REQUEST_LIMIT_RESET;
            age_limit_reg     <= lsw_pkg::AGE_LIMIT_RESET;
        end
        else
        begin
            state_reg         <= state_next;
            count_reg         <= count_next;
            now_reg           <= now_next;
            out_valid_reg     <= out_valid_next;
            allowed_reg       <= allowed_next;
            live_count_reg    <= live_count_next;
            request_limit_reg <= request_limit_next;
            age_limit_reg     <= age_limit_next;
        end
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign res.valid      = out_valid_reg;
    assign res.allowed    = allowed_reg;
    assign res.live_count = live_count_reg;

endmodule

### sv/lsw_cell.sv
module lsw_cell (
    input  logic                clk,
    input  lsw_pkg::cell_ctrl_t ctrl,
    input  lsw_pkg::stamp_t     now,
    input  lsw_pkg::stamp_t     neighbor,
    output lsw_pkg::stamp_t     stamp
);

    lsw_pkg::stamp_t stamp_reg;
    lsw_pkg::stamp_t stamp_next;

    // shift moves the entry one place toward the head; load takes the new beat's time
    always_comb
    begin
        stamp_next = stamp_reg;
        if (ctrl.shift)
        begin
            stamp_next = neighbor;
        end
        else if (ctrl.load)
        begin
            stamp_next = now;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
    end

    assign stamp = stamp_reg;

endmodule

### sv/lsw_checker.sv
module lsw_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_ready,
    input logic                               res_valid,
    input logic                               res_ready,
    input logic                               res_allowed,
    input logic [lsw_pkg::COUNT_OUT_W-1:0]    res_live_count
);

    // a pending result beat stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped before taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_allowed) && $stable(res_live_count))
    else $error("stalled result beat changed");

    // one request in flight: busy the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one in work");

    // a new result only comes out of a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!req_ready))
    else $error("result beat without a request in work");

endmodule

bind sliding_window_log_rate_limiter lsw_checker u_lsw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_allowed    (res.allowed),
    .res_live_count (res.live_count)
);

### test/tb_sliding_window_log_rate_limiter.sv
`timescale 1ns / 1ps

module tb_sliding_window_log_rate_limiter;

    localparam int LOG_DEPTH    = 16;
    localparam int TARGET_ITEMS = 1750;

    typedef struct packed {
        logic                            allowed;
        logic [lsw_pkg::COUNT_OUT_W-1:0] live_count;
    } verdict_t;

    // Admission log predictor plus the queue of verdicts still owed by the block.
    class rate_log_board;
        lsw_pkg::stamp_t                  admitted_log [LOG_DEPTH];
        logic [3:0]                       head;
        logic [4:0]                       fill;
        logic [lsw_pkg::LIMIT_W-1:0]      limit_reg;
        logic [lsw_pkg::AGE_W-1:0]        age_reg;
        verdict_t                         due [$];
        int unsigned                      errors;
        int unsigned                      admits;
        int unsigned                      denies;

        function new();
            head      = '0;
            fill      = '0;
            limit_reg = lsw_pkg::REQUEST_LIMIT_RESET;
            age_reg   = lsw_pkg::AGE_LIMIT_RESET;
            errors    = 0;
            admits    = 0;
            denies    = 0;
            foreach (admitted_log[i])
                admitted_log[i] = '0;
        endfunction

        function void set_register(logic [lsw_pkg::CFG_IDX_W-1:0] index,
                                   logic [lsw_pkg::CFG_DATA_W-1:0] data);
            if (index == lsw_pkg::CFG_REQUEST_LIMIT)
                limit_reg = data[lsw_pkg::LIMIT_W-1:0];
            else
                age_reg = data[lsw_pkg::AGE_W-1:0];
        endfunction

        function bit still_live(lsw_pkg::stamp_t now, lsw_pkg::stamp_t entry);
            lsw_pkg::stamp_t age;
            age = now - entry;
            return age < lsw_pkg::stamp_t'(age_reg);
        endfunction

        function void log_time(lsw_pkg::stamp_t now);
            logic [3:0] slot;
            if (fill < LOG_DEPTH)
            begin
                slot = head + fill[3:0];
                admitted_log[slot] = now;
                fill++;
            end
        endfunction

        function void note_request(lsw_pkg::stamp_t now);
            int unsigned eff_limit;
            verdict_t    v;
            eff_limit = limit_reg;
            if (eff_limit < 1)
                eff_limit = 1;
            if (eff_limit > LOG_DEPTH)
                eff_limit = LOG_DEPTH;
            if (fill < eff_limit)
            begin
                log_time(now);
                v.allowed = 1'b1;
            end
            else if (still_live(now, admitted_log[head]))
            begin
                v.allowed = 1'b0;
            end
            else
            begin
                while (fill > 0 && !still_live(now, admitted_log[head]))
                begin
                    head++;
                    fill--;
                end
                log_time(now);
                v.allowed = 1'b1;
            end
            v.live_count = fill;
            if (v.allowed)
                admits++;
            else
                denies++;
            due.push_back(v);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        task check_verdict(logic allowed, logic [lsw_pkg::COUNT_OUT_W-1:0] live_count);
            verdict_t want;
            if (due.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing pending (allowed %b count %0d)",
                                          allowed, live_count));
                return;
            end
            want = due.pop_front();
            if (allowed !== want.allowed)
                report_mismatch($sformatf("allowed %b, want %b", allowed, want.allowed));
            if (live_count !== want.live_count)
                report_mismatch($sformatf("live_count %0d, want %0d", live_count,
                                          want.live_count));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic                             cfg_we;
    logic [lsw_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [lsw_pkg::CFG_DATA_W-1:0]   cfg_data;

    lsw_req_if req_ch ();
    lsw_res_if res_ch ();

    rate_log_board board = new();

    int unsigned     burst_left;
    int unsigned     sent_items;
    int unsigned     settings_used;
    lsw_pkg::stamp_t last_stamp;

    sliding_window_log_rate_limiter #(
        .LOG_DEPTH(LOG_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d verdicts pending", board.due.size());
        $display("tb_sliding_window_log_rate_limiter: done, errors");
        $finish;
    end

    // beat monitor
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            board.check_verdict(res_ch.allowed, res_ch.live_count);
        if (rst_n && req_ch.valid && req_ch.ready)
            board.note_request(req_ch.request_time);
    end

    // result stall pattern
    initial
    begin
        int unsigned mode;
        int unsigned left;
        res_ch.ready = 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 300);
            end
            left--;
            case (mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                2: res_ch.ready <= (left % 5 == 0);
                default: res_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic write_reg(logic [lsw_pkg::CFG_IDX_W-1:0] index,
                             logic [lsw_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        board.set_register(index, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(logic [lsw_pkg::LIMIT_W-1:0] limit,
                              logic [lsw_pkg::AGE_W-1:0] age);
        logic [lsw_pkg::CFG_DATA_W-1:0] data;
        data = $urandom_range(0, 3) == 0 ? $urandom : '0;
        data[lsw_pkg::LIMIT_W-1:0] = limit;
        write_reg(lsw_pkg::CFG_REQUEST_LIMIT, data);
        write_reg(lsw_pkg::CFG_AGE_LIMIT, age);
        settings_used++;
    endtask

    task automatic send_request(lsw_pkg::stamp_t stamp);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        req_ch.valid        <= 1'b1;
        req_ch.request_time <= stamp;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent_items++;
        last_stamp = stamp;
    endtask

    task automatic settle();
        @(posedge clk);
        while (board.due.size() != 0)
            @(posedge clk);
        repeat (LOG_DEPTH + 4) @(posedge clk);
    endtask

    task automatic run_batch(lsw_pkg::stamp_t stamps [$]);
        foreach (stamps[i])
            send_request(stamps[i]);
        req_ch.valid <= 1'b0;
        settle();
    endtask

    task automatic random_phase();
        logic [lsw_pkg::LIMIT_W-1:0] limit;
        logic [lsw_pkg::AGE_W-1:0]   age;
        lsw_pkg::stamp_t             now;
        lsw_pkg::stamp_t             stamps [$];
        longint unsigned             span;
        longint unsigned             step;
        int unsigned                 eff;
        int unsigned                 n;
        case ($urandom_range(0, 7))
            0: limit = 0;
            1: limit = 1;
            2: limit = 16;
            3: limit = lsw_pkg::LIMIT_W'($urandom_range(17, 31));
            default: limit = lsw_pkg::LIMIT_W'($urandom_range(2, 15));
        endcase
        case ($urandom_range(0, 7))
            0: age = 0;
            1: age = $urandom_range(1, 8);
            2: age = 32'hFFFF_FFFF;
            3: age = lsw_pkg::AGE_LIMIT_RESET;
            4: age = $urandom;
            default: age = $urandom_range(16, 5000);
        endcase
        case ($urandom_range(0, 3))
            0: now = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 5000);
            1: now = last_stamp;
            default: now = lsw_pkg::stamp_t'({$urandom, $urandom});
        endcase
        eff = (limit == 0) ? 1 : (limit > LOG_DEPTH) ? LOG_DEPTH : limit;
        span = (2 * longint'(age)) / eff + 1;
        n = $urandom_range(40, 160);
        repeat (n)
        begin
            case ($urandom_range(0, 19))
                0: now = lsw_pkg::stamp_t'({$urandom, $urandom});
                1, 2, 3, 4: now = now;
                default:
                begin
                    step = {$urandom, $urandom} % span;
                    now  = now + lsw_pkg::stamp_t'(step);
                end
            endcase
            stamps.push_back(now);
        end
        set_limits(limit, age);
        run_batch(stamps);
    endtask

    initial
    begin
        lsw_pkg::stamp_t stamps [$];
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.request_time = '0;
        burst_left          = 0;
        sent_items          = 0;
        settings_used       = 1;
        last_stamp          = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        stamps = '{48'd7, 48'd7, 48'd2000007};
        run_batch(stamps);

        // zero limit acts as one, zero age never live, top and bottom of the time range
        set_limits(5'd0, 32'd0);
        stamps = '{48'hFFFF_FFFF_FFFF, 48'd0};
        run_batch(stamps);

        // single entry, widest age, then a time that runs backwards
        set_limits(5'd1, 32'hFFFF_FFFF);
        stamps = '{48'd10, 48'h8000_0000_0000, 48'h0000_0000_1000};
        run_batch(stamps);

        // limit above depth: fill the whole log, then deny
        set_limits(5'd31, 32'd100);
        stamps.delete();
        for (int i = 0; i <= 16; i++)
            stamps.push_back(48'hABCD_0000_0000 + i);
        run_batch(stamps);

        // limit dropped below the fill: partial clear keeps the count above the limit
        write_reg(lsw_pkg::CFG_REQUEST_LIMIT, 32'd3);
        stamps = '{48'hABCD_0000_0000 + 105, 48'hABCD_0000_0000 + 106};
        run_batch(stamps);

        while (sent_items < TARGET_ITEMS)
            random_phase();

        repeat (LOG_DEPTH + 4) @(posedge clk);
        if (board.due.size() != 0)
            board.report_mismatch($sformatf("%0d verdicts never arrived", board.due.size()));
        $display("covered %0d requests over %0d limit/age settings", sent_items, settings_used);
        $display("verdicts: %0d admitted, %0d denied", board.admits, board.denies);
        if (board.errors == 0)
            $display("tb_sliding_window_log_rate_limiter: done, clean");
        else
            $display("tb_sliding_window_log_rate_limiter: done, errors");
        $finish;
    end

endmodule
